@@ sv/ple_pkg.sv @@
// Package for the positional list engine: field widths, command and status
// codes, and the broadcast struct that the top level sends to every cell.
// No dependencies.
package ple_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 8;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

  localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOCHANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } ple_op_t;

  typedef struct packed {
    ple_op_t                   op;
    logic [CNT_W-1:0]          pos;    // zero-based
    logic [CNT_W-1:0]          cnt;    // count before the operation
    logic signed [DATA_W-1:0]  value;
  } ple_bcast_t;

endpackage

@@ sv/ple_cell.sv @@
// One list cell: holds the element at its position and takes the value,
// its lower or its upper neighbour, or the head, as the broadcast says.
// Depends on ple_pkg.
module ple_cell (
  input  logic                          clk,
  input  logic [ple_pkg::CNT_W-1:0]     idx_i,
  input  ple_pkg::ple_bcast_t           bc_i,
  input  logic signed [ple_pkg::DATA_W-1:0] prev_i,
  input  logic signed [ple_pkg::DATA_W-1:0] next_i,
  input  logic signed [ple_pkg::DATA_W-1:0] head_i,
  output logic signed [ple_pkg::DATA_W-1:0] data_o
);
  import ple_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic [CNT_W-1:0]         idx_p1;

  assign idx_p1 = idx_i + 7'd1;

  always_comb begin
    data_nxt = data_r;
    case (bc_i.op)
      OP_INS: begin
        if (idx_i == bc_i.pos) begin
          data_nxt = bc_i.value;
        end else if (idx_i > bc_i.pos) begin
          data_nxt = prev_i;
        end
      end
      OP_DEL: begin
        if (idx_i >= bc_i.pos) begin
          data_nxt = next_i;
        end
      end
      OP_ROT: begin
        // head wraps round to the last occupied cell
        if (idx_p1 == bc_i.cnt) begin
          data_nxt = head_i;
        end else if (idx_p1 < bc_i.cnt) begin
          data_nxt = next_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

@@ sv/positional_list_engine_top.sv @@
// Positional list engine: a row of CAPACITY cells holding a packed list of
// signed 32-bit values. Every command but dump yields one result; the cells
// compare their index with the position and shift as the command is taken.
// A dump of an empty list likewise yields one result; any other dump enters
// the dump state on its transfer, then gives one element per result, rotating
// the row past the head cell and waiting while a result is not taken. A new
// command is taken once the dump is over and the result register is free.
// The result register lets a command be taken while its predecessor's result
// is still waiting, as long as that result is taken in the same cycle.
// Depends on ple_pkg and ple_cell.
module positional_list_engine_top #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ple_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [ple_pkg::DATA_W-1:0] in_value,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ple_pkg::ST_W-1:0]          out_status,
  output logic [ple_pkg::CNT_W-1:0]         out_count,
  output logic signed [ple_pkg::DATA_W-1:0] out_element,
  output logic [ple_pkg::CNT_W-1:0]         out_element_index,
  output logic                              out_last
);
  import ple_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CNT_W-1:0]         dump_idx_r;
  logic [CNT_W-1:0]         dump_idx_p1;
  logic                     out_valid_r;
  logic [ST_W-1:0]          out_status_r;
  logic [ST_W-1:0]          status_nxt;
  logic [CNT_W-1:0]         out_count_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic [CNT_W-1:0]         out_index_r;
  logic                     out_last_r;

  logic       out_free;
  logic       accept;
  logic       emit;
  logic       load_out;
  logic       full;
  logic       ins_pos_ok;
  logic       del_pos_ok;
  ple_bcast_t bc;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE) && out_free;
  assign accept      = in_valid && in_ready;
  assign emit        = (state_r == S_DUMP) && out_free;
  // a non-empty dump produces nothing in its transfer cycle
  assign load_out    = emit || (accept && !(in_cmd == CMD_DUMP && count_r != '0));
  assign full        = (count_r >= CAP);
  assign dump_idx_p1 = dump_idx_r + 7'd1;
  assign ins_pos_ok  = (in_position != 8'd0) && (in_position <= (POS_W'(count_r) + 8'd1));
  assign del_pos_ok  = (in_position != 8'd0) && (in_position <= POS_W'(count_r));

  always_comb begin
    bc.op      = OP_HOLD;
    bc.pos     = '0;
    bc.cnt     = count_r;
    bc.value   = in_value;
    status_nxt = ST_NOCHANGE;
    count_nxt  = count_r;
    if (emit) begin
      bc.op = OP_ROT;
    end else if (accept) begin
      case (in_cmd)
        CMD_INS_FRONT, CMD_INS_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            bc.op      = OP_INS;
            bc.pos     = (in_cmd == CMD_INS_FRONT) ? '0 : count_r;
            status_nxt = ST_DONE;
            count_nxt  = count_r + 7'd1;
          end
        end
        CMD_INS_AT: begin
          if (!ins_pos_ok) begin
            status_nxt = ST_NOCHANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            bc.op      = OP_INS;
            bc.pos     = CNT_W'(in_position - 8'd1);
            status_nxt = ST_DONE;
            count_nxt  = count_r + 7'd1;
          end
        end
        CMD_DEL_FRONT, CMD_DEL_BACK: begin
          if (count_r != '0) begin
            bc.op      = OP_DEL;
            bc.pos     = (in_cmd == CMD_DEL_FRONT) ? '0 : (count_r - 7'd1);
            status_nxt = ST_DONE;
            count_nxt  = count_r - 7'd1;
          end
        end
        CMD_DEL_AT: begin
          if (del_pos_ok) begin
            bc.op      = OP_DEL;
            bc.pos     = CNT_W'(in_position - 8'd1);
            status_nxt = ST_DONE;
            count_nxt  = count_r - 7'd1;
          end
        end
        CMD_DUMP: status_nxt = ST_DONE;
        default:  status_nxt = ST_NOCHANGE;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev_d;
    logic signed [DATA_W-1:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = cell_q[g];
    end else begin : g_mid_lo
      assign prev_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_d = cell_q[g];
    end else begin : g_mid_hi
      assign next_d = cell_q[g+1];
    end
    ple_cell u_cell (
      .clk    (clk),
      .idx_i  (CNT_W'(g)),
      .bc_i   (bc),
      .prev_i (prev_d),
      .next_i (next_d),
      .head_i (cell_q[0]),
      .data_o (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        out_status_r  <= ST_DONE;
        out_count_r   <= count_r;
        out_element_r <= cell_q[0];
        out_index_r   <= dump_idx_p1;
        out_last_r    <= (dump_idx_p1 == count_r);
        dump_idx_r    <= dump_idx_p1;
        if (dump_idx_p1 == count_r) begin
          state_r <= S_IDLE;
        end
      end else if (accept) begin
        count_r <= count_nxt;
        if (in_cmd == CMD_DUMP && count_r != '0) begin
          state_r    <= S_DUMP;
          dump_idx_r <= '0;
        end else begin
          out_status_r  <= status_nxt;
          out_count_r   <= count_nxt;
          out_element_r <= '0;
          out_index_r   <= '0;
          out_last_r    <= 1'b1;
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_count         = out_count_r;
  assign out_element       = out_element_r;
  assign out_element_index = out_index_r;
  assign out_last          = out_last_r;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("element count above capacity");

  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> !in_ready)
    else $error("command taken during dump");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd != CMD_DUMP |=> out_valid && out_last && out_element_index == '0)
    else $error("command transfer without its result");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_index != '0 |-> out_element_index <= out_count)
    else $error("dump index beyond count");
`endif

endmodule
